// File: src/pidfd_pkg.sv
// Shared types, constants and fixed-point helpers for the filtered-derivative PID block.
package pidfd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DW1        = DATA_WIDTH + 1;
  localparam int DW2        = 2 * DATA_WIDTH;
  localparam int CFG_IDX_W  = 8;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Register reset values
  localparam word_t RST_PROP_GAIN   = word_t'(65536);
  localparam word_t RST_INT_COEF    = word_t'(328);
  localparam word_t RST_DERIV_COEF  = word_t'(1192);
  localparam word_t RST_DERIV_DECAY = word_t'(53620);
  localparam word_t RST_OUT_MAX     = word_t'(6553600);
  localparam word_t RST_OUT_MIN     = word_t'(-6553600);
  localparam word_t RST_INTEG_MAX   = word_t'(3276800);
  localparam word_t RST_INTEG_MIN   = word_t'(-3276800);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 8'd0,
    REG_INT_COEF    = 8'd1,
    REG_DERIV_COEF  = 8'd2,
    REG_DERIV_DECAY = 8'd3,
    REG_OUT_MAX     = 8'd4,
    REG_OUT_MIN     = 8'd5,
    REG_INTEG_MAX   = 8'd6,
    REG_INTEG_MIN   = 8'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LIM_NONE = 2'd0,
    LIM_HIGH = 2'd1,
    LIM_LOW  = 2'd2
  } lim_t;

  typedef struct packed {
    word_t prop_gain;
    word_t int_coef;
    word_t deriv_coef;
    word_t deriv_decay;
    word_t out_max;
    word_t out_min;
    word_t integ_max;
    word_t integ_min;
  } cfg_t;

  // Products leaving the front end
  typedef struct packed {
    word_t p;
    word_t iinc;
    word_t dinc;
  } prod_t;

  // Accumulator stage result
  typedef struct packed {
    word_t p;
    word_t integ;
    word_t deriv;
    logic  ilim;
  } acc_t;

  typedef struct packed {
    word_t val;
    logic  hi;
    logic  lo;
  } clamp_t;

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [DW1-1:0] s;
    s = DW1'(a) + DW1'(b);
    if (s[DW1-1] != s[DW1-2]) begin
      return s[DW1-1] ? WORD_MIN : WORD_MAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic signed [DW1-1:0] s;
    s = DW1'(a) - DW1'(b);
    if (s[DW1-1] != s[DW1-2]) begin
      return s[DW1-1] ? WORD_MIN : WORD_MAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  // Full product, floor shift by the fraction bits, saturate
  function automatic word_t fmul(input word_t a, input word_t b);
    logic signed [DW2-1:0] prod;
    logic signed [DW2-1:0] sh;
    prod = DW2'(a) * DW2'(b);
    sh   = prod >>> FRAC_BITS;
    if (!sh[DW2-1] && (|sh[DW2-2:DATA_WIDTH-1])) begin
      return WORD_MAX;
    end
    if (sh[DW2-1] && !(&sh[DW2-2:DATA_WIDTH-1])) begin
      return WORD_MIN;
    end
    return sh[DATA_WIDTH-1:0];
  endfunction

  // Upper limit is tested first; with crossed limits only values above it take it
  function automatic clamp_t clamp(input word_t v, input word_t hi, input word_t lo);
    clamp_t c;
    c.val = v;
    c.hi  = 1'b0;
    c.lo  = 1'b0;
    if (v > hi) begin
      c.val = hi;
      c.hi  = 1'b1;
    end else if (v < lo) begin
      c.val = lo;
      c.lo  = 1'b1;
    end
    return c;
  endfunction

endpackage

// File: src/pidfd_cfg.sv
// Coefficient and limit register file with its write port.
module pidfd_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  pidfd_pkg::word_t                     cfg_wdata,
  output pidfd_pkg::cfg_t                      cfg
);
  import pidfd_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain   <= RST_PROP_GAIN;
      cfg_r.int_coef    <= RST_INT_COEF;
      cfg_r.deriv_coef  <= RST_DERIV_COEF;
      cfg_r.deriv_decay <= RST_DERIV_DECAY;
      cfg_r.out_max     <= RST_OUT_MAX;
      cfg_r.out_min     <= RST_OUT_MIN;
      cfg_r.integ_max   <= RST_INTEG_MAX;
      cfg_r.integ_min   <= RST_INTEG_MIN;
    end else if (cfg_valid && cfg_ready) begin
      // drop writes to unmapped indexes
      unique case (cfg_index)
        REG_PROP_GAIN:   cfg_r.prop_gain   <= cfg_wdata;
        REG_INT_COEF:    cfg_r.int_coef    <= cfg_wdata;
        REG_DERIV_COEF:  cfg_r.deriv_coef  <= cfg_wdata;
        REG_DERIV_DECAY: cfg_r.deriv_decay <= cfg_wdata;
        REG_OUT_MAX:     cfg_r.out_max     <= cfg_wdata;
        REG_OUT_MIN:     cfg_r.out_min     <= cfg_wdata;
        REG_INTEG_MAX:   cfg_r.integ_max   <= cfg_wdata;
        REG_INTEG_MIN:   cfg_r.integ_min   <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// File: src/pidfd_front.sv
// Input register, error and difference forming, and the three independent products.
module pidfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pidfd_pkg::word_t  in_target,
  input  pidfd_pkg::word_t  in_sensed,
  input  pidfd_pkg::cfg_t   cfg,
  output logic              prod_valid,
  input  logic              prod_ready,
  output pidfd_pkg::prod_t  prod
);
  import pidfd_pkg::*;

  logic  v1_r, v2_r, v3_r;
  logic  ready1, ready2, ready3;
  word_t target_r, sensed_r;
  word_t err_r, err_sum_r, sens_diff_r;
  word_t last_error_r, last_sensed_r;
  word_t err_nxt;
  prod_t prod_r;

  assign ready3   = !v3_r || prod_ready;
  assign ready2   = !v2_r || ready3;
  assign ready1   = !v1_r || ready2;
  assign in_stall = !ready1;

  assign err_nxt    = sat_sub(target_r, sensed_r);
  assign prod_valid = v3_r;
  assign prod       = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
      last_error_r  <= '0;
      last_sensed_r <= '0;
    end else begin
      if (ready1) v1_r <= in_valid;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
      // history advances only as an item moves into the difference stage
      if (v1_r && ready2) begin
        last_error_r  <= err_nxt;
        last_sensed_r <= sensed_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready1) begin
      target_r <= in_target;
      sensed_r <= in_sensed;
    end
    if (v1_r && ready2) begin
      err_r       <= err_nxt;
      err_sum_r   <= sat_add(err_nxt, last_error_r);
      sens_diff_r <= sat_sub(sensed_r, last_sensed_r);
    end
    if (v2_r && ready3) begin
      prod_r.p    <= fmul(cfg.prop_gain, err_r);
      prod_r.iinc <= fmul(cfg.int_coef, err_sum_r);
      prod_r.dinc <= fmul(cfg.deriv_coef, sens_diff_r);
    end
  end

endmodule

// File: src/pidfd_loop.sv
// Integrator with anti-windup clamp and the first-order derivative filter state.
module pidfd_loop (
  input  logic              clk,
  input  logic              rst_n,
  input  pidfd_pkg::cfg_t   cfg,
  input  logic              prod_valid,
  output logic              prod_ready,
  input  pidfd_pkg::prod_t  prod,
  output logic              acc_valid,
  input  logic              acc_ready,
  output pidfd_pkg::acc_t   acc
);
  import pidfd_pkg::*;

  logic   v4_r;
  logic   ready4;
  word_t  integ_acc_r, deriv_acc_r, p_r;
  logic   ilim_r;
  clamp_t integ_c;
  word_t  deriv_nxt;

  assign ready4     = !v4_r || acc_ready;
  assign prod_ready = ready4;

  assign integ_c   = clamp(sat_add(integ_acc_r, prod.iinc), cfg.integ_max, cfg.integ_min);
  assign deriv_nxt = sat_sub(fmul(cfg.deriv_decay, deriv_acc_r), prod.dinc);

  assign acc_valid = v4_r;
  assign acc.p     = p_r;
  assign acc.integ = integ_acc_r;
  assign acc.deriv = deriv_acc_r;
  assign acc.ilim  = ilim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r        <= 1'b0;
      integ_acc_r <= '0;
      deriv_acc_r <= '0;
    end else begin
      if (ready4) v4_r <= prod_valid;
      if (prod_valid && ready4) begin
        integ_acc_r <= integ_c.val;
        deriv_acc_r <= deriv_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && ready4) begin
      p_r    <= prod.p;
      ilim_r <= integ_c.hi | integ_c.lo;
    end
  end

endmodule

// File: src/pidfd_mix.sv
// Term summation, output clamp and the result register.
module pidfd_mix (
  input  logic                clk,
  input  logic                rst_n,
  input  pidfd_pkg::cfg_t     cfg,
  input  logic                acc_valid,
  output logic                acc_ready,
  input  pidfd_pkg::acc_t     acc,
  output logic                out_valid,
  input  logic                out_stall,
  output pidfd_pkg::word_t    out_drive,
  output logic [1:0]          out_drive_limited,
  output logic                out_integ_limited
);
  import pidfd_pkg::*;

  logic   v5_r, out_valid_r;
  logic   ready5, ready6;
  word_t  pi_sum_r, deriv_r;
  logic   ilim5_r;
  word_t  drive_r;
  lim_t   dlim_r;
  logic   ilim_r;
  clamp_t drive_c;
  lim_t   dlim_nxt;

  assign ready6    = !out_valid_r || !out_stall;
  assign ready5    = !v5_r || ready6;
  assign acc_ready = ready5;

  assign drive_c = clamp(sat_add(pi_sum_r, deriv_r), cfg.out_max, cfg.out_min);

  always_comb begin
    dlim_nxt = LIM_NONE;
    if (drive_c.hi) begin
      dlim_nxt = LIM_HIGH;
    end else if (drive_c.lo) begin
      dlim_nxt = LIM_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready5) v5_r <= acc_valid;
      if (ready6) out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_valid && ready5) begin
      pi_sum_r <= sat_add(acc.p, acc.integ);
      deriv_r  <= acc.deriv;
      ilim5_r  <= acc.ilim;
    end
    if (v5_r && ready6) begin
      drive_r <= drive_c.val;
      dlim_r  <= dlim_nxt;
      ilim_r  <= ilim5_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive         = drive_r;
  assign out_drive_limited = dlim_r;
  assign out_integ_limited = ilim_r;

endmodule

// File: src/pid_controller_filtered_derivative_top.sv
// Discrete PID controller with clamped trapezoidal integrator and filtered derivative.
// Takes one setpoint/measurement pair per clock while in_stall is low and returns one
// clamped drive value per pair, in order, through the register stages listed below.
// Internally six register stages: input, error and differences, the three gain products,
// the integrator and derivative filter state, the P+I sum, and the clamped result. The
// one-per-cycle rate is set by the derivative filter update, where the pole multiply,
// subtract and saturate close on the filter state register, and the integrator add
// and clamp close on their own register in the same stage. Each stage moves on as
// soon as the next one is empty or emptying, so bubbles collapse and input is still
// taken while a finished result waits on a stalled output. All values are signed
// Q16.16, products floor-shifted and saturated, sums saturated. Coefficients and
// limits are written through the cfg port (indexes 0..7; others are dropped); the user
// must write them only while no item is in flight, which the block does not enforce.
module pid_controller_filtered_derivative_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pidfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  pidfd_pkg::word_t                 cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pidfd_pkg::word_t                 in_target,
  input  pidfd_pkg::word_t                 in_sensed,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pidfd_pkg::word_t                 out_drive,
  output logic [1:0]                       out_drive_limited,
  output logic                             out_integ_limited
);
  import pidfd_pkg::*;

  cfg_t  cfg;
  prod_t prod;
  acc_t  acc;
  logic  prod_valid, prod_ready;
  logic  acc_valid, acc_ready;

  pidfd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pidfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_target  (in_target),
    .in_sensed  (in_sensed),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  pidfd_loop u_loop (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .acc_valid  (acc_valid),
    .acc_ready  (acc_ready),
    .acc        (acc)
  );

  pidfd_mix u_mix (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .acc_valid         (acc_valid),
    .acc_ready         (acc_ready),
    .acc               (acc),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive         (out_drive),
    .out_drive_limited (out_drive_limited),
    .out_integ_limited (out_integ_limited)
  );

endmodule

// File: tb/sv/pid_controller_filtered_derivative_top_test.sv
// Self-checking testbench for the filtered-derivative PID block: bit-exact predictor, random traffic.
module pid_controller_filtered_derivative_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pidfd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_INDEX = 8'd8;
  localparam logic [CFG_IDX_W-1:0] LAST_UNUSED_INDEX  = 8'hFF;
  localparam int RANDOM_PHASES    = 7;
  localparam int ITEMS_PER_PHASE  = 122;
  localparam int MAX_REPORTS      = 10;
  localparam int SETTLE_CYCLES    = 20;

  typedef struct {
    word_t target;
    word_t sensed;
  } sample_t;

  typedef struct {
    word_t drive;
    lim_t  lim;
    logic  ilim;
  } drive_exp_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic  [CFG_IDX_W-1:0] cfg_index = '0;
  word_t cfg_wdata = '0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t in_target = '0;
  word_t in_sensed = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t out_drive;
  logic  [1:0] out_drive_limited;
  logic  out_integ_limited;

  pid_controller_filtered_derivative_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_target         (in_target),
    .in_sensed         (in_sensed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive         (out_drive),
    .out_drive_limited (out_drive_limited),
    .out_integ_limited (out_integ_limited)
  );

  always #1 clk = ~clk;

  // Predictor state and register shadow
  cfg_t  gains = '{prop_gain: RST_PROP_GAIN, int_coef: RST_INT_COEF,
                   deriv_coef: RST_DERIV_COEF, deriv_decay: RST_DERIV_DECAY,
                   out_max: RST_OUT_MAX, out_min: RST_OUT_MIN,
                   integ_max: RST_INTEG_MAX, integ_min: RST_INTEG_MIN};
  word_t integ_st = '0;
  word_t deriv_st = '0;
  word_t prev_err = '0;
  word_t prev_sensed = '0;

  sample_t    sample_q[$];
  drive_exp_t drive_q[$];
  int         mismatches = 0;
  logic       hold_off = 1'b0;
  bit         pressure_go = 1'b0;

  function automatic word_t clip_word(input longint v);
    if (v > longint'(WORD_MAX)) return WORD_MAX;
    if (v < longint'(WORD_MIN)) return WORD_MIN;
    return word_t'(v);
  endfunction

  function automatic word_t qmul_floor(input word_t a, input word_t b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return clip_word(prod >>> FRAC_BITS);
  endfunction

  function automatic longint wide(input word_t v);
    return longint'(v);
  endfunction

  // Advance the controller state by one sample and queue the drive it yields
  task automatic predict_drive(input word_t target, input word_t sensed);
    word_t err, pterm, ierr, dstep, pi_sum, y;
    drive_exp_t r;
    err   = clip_word(wide(target) - wide(sensed));
    pterm = qmul_floor(gains.prop_gain, err);
    ierr  = clip_word(wide(err) + wide(prev_err));
    integ_st = clip_word(wide(integ_st) + wide(qmul_floor(gains.int_coef, ierr)));
    r.ilim = 1'b0;
    if (integ_st > gains.integ_max) begin
      integ_st = gains.integ_max;
      r.ilim = 1'b1;
    end else if (integ_st < gains.integ_min) begin
      integ_st = gains.integ_min;
      r.ilim = 1'b1;
    end
    dstep    = clip_word(wide(sensed) - wide(prev_sensed));
    deriv_st = clip_word(wide(qmul_floor(gains.deriv_decay, deriv_st))
                         - wide(qmul_floor(gains.deriv_coef, dstep)));
    pi_sum = clip_word(wide(pterm) + wide(integ_st));
    y      = clip_word(wide(pi_sum) + wide(deriv_st));
    r.lim  = LIM_NONE;
    if (y > gains.out_max) begin
      y = gains.out_max;
      r.lim = LIM_HIGH;
    end else if (y < gains.out_min) begin
      y = gains.out_min;
      r.lim = LIM_LOW;
    end
    r.drive = y;
    prev_err = err;
    prev_sensed = sensed;
    drive_q.push_back(r);
  endtask

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // Input driver: bursts of transfers separated by random gaps
  int      burst_left = 0;
  int      gap_left = 0;
  sample_t nxt;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_drive(in_target, in_sensed);
      if (in_valid && in_stall) begin
        // hold the stalled payload
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (sample_q.size() != 0) begin
        nxt = sample_q.pop_front();
        in_valid  <= 1'b1;
        in_target <= nxt.target;
        in_sensed <= nxt.sensed;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, changing mode every so often
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          stall_phase = 0;
  logic        busy;

  always @(posedge clk) begin
    if (rst_n) begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      stall_phase = (stall_phase + 1) % 5;
      case (stall_mode)
        STALL_NONE:  busy = 1'b0;
        STALL_LIGHT: busy = ($urandom_range(0, 3) == 0);
        STALL_HEAVY: busy = ($urandom_range(0, 3) != 0);
        default:     busy = (stall_phase < 2);
      endcase
      out_stall <= hold_off | busy;
    end
  end

  // Long hold-off so the pipeline fills and backs up into the input
  initial begin
    wait (pressure_go);
    repeat (40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Result monitor
  drive_exp_t exp_r;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        note_error($sformatf("unexpected result drive=%0d lim=%0d ilim=%0d",
                             out_drive, out_drive_limited, out_integ_limited));
      end else begin
        exp_r = drive_q.pop_front();
        if (out_drive !== exp_r.drive || out_drive_limited !== exp_r.lim ||
            out_integ_limited !== exp_r.ilim)
          note_error($sformatf("drive %0d/%0d lim %0d/%0d ilim %0d/%0d (exp/got)",
                               exp_r.drive, out_drive, exp_r.lim, out_drive_limited,
                               exp_r.ilim, out_integ_limited));
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= REG_INTEG_MIN) begin
      case (cfg_reg_t'(idx))
        REG_PROP_GAIN:   gains.prop_gain   = val;
        REG_INT_COEF:    gains.int_coef    = val;
        REG_DERIV_COEF:  gains.deriv_coef  = val;
        REG_DERIV_DECAY: gains.deriv_decay = val;
        REG_OUT_MAX:     gains.out_max     = val;
        REG_OUT_MIN:     gains.out_min     = val;
        REG_INTEG_MAX:   gains.integ_max   = val;
        default:         gains.integ_min   = val;
      endcase
    end
  endtask

  task automatic push_sample(input word_t target, input word_t sensed);
    sample_t s;
    s.target = target;
    s.sensed = sensed;
    sample_q.push_back(s);
  endtask

  // Wait for every transfer and result, then let the pipeline settle;
  // sample on the falling edge so queue and driver state are stable
  task automatic drain();
    do @(negedge clk); while (sample_q.size() != 0 || in_valid || drive_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return word_t'($urandom_range(0, 2000000)) - word_t'(1000000);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t pick_limit();
    return word_t'($urandom_range(1, 400)) <<< FRAC_BITS;
  endfunction

  initial begin
    int    setpoint;
    int    plant;
    word_t lim_hi;
    word_t lim_lo;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset gains: saturating errors, integrator wound into both limits
    push_sample('0, '0);
    push_sample(WORD_MAX, WORD_MIN);
    push_sample(WORD_MIN, WORD_MAX);
    push_sample(WORD_MAX, WORD_MAX);
    push_sample(WORD_MIN, WORD_MIN);
    repeat (3) push_sample(WORD_MAX, '0);
    repeat (3) push_sample(WORD_MIN, '0);
    push_sample(word_t'(-1), word_t'(1));
    push_sample(word_t'(1), word_t'(-1));
    push_sample(word_t'(32'sd655360), word_t'(32'sd131072));
    drain();

    // Extreme register values, plus writes to unused indexes that must be dropped
    write_reg(REG_PROP_GAIN, WORD_MAX);
    write_reg(REG_INT_COEF, WORD_MIN);
    write_reg(REG_DERIV_COEF, WORD_MAX);
    write_reg(REG_DERIV_DECAY, WORD_MIN);
    write_reg(REG_OUT_MAX, WORD_MAX);
    write_reg(REG_OUT_MIN, WORD_MIN);
    write_reg(REG_INTEG_MAX, WORD_MAX);
    write_reg(REG_INTEG_MIN, WORD_MIN);
    write_reg(FIRST_UNUSED_INDEX, '0);
    write_reg(LAST_UNUSED_INDEX, word_t'(32'sd12345));
    push_sample(WORD_MAX, WORD_MIN);
    push_sample(WORD_MIN, WORD_MAX);
    push_sample('0, '0);
    push_sample(word_t'(32'h1234_5678), word_t'(32'hEDCB_A988));
    push_sample(word_t'(1), '0);
    push_sample(word_t'(-1), '0);
    drain();

    // Crossed limits: values above the upper bound take it, all others take the lower bound
    write_reg(REG_OUT_MAX, word_t'(-65536));
    write_reg(REG_OUT_MIN, word_t'(65536));
    write_reg(REG_INTEG_MAX, word_t'(-100));
    write_reg(REG_INTEG_MIN, word_t'(100));
    write_reg(REG_PROP_GAIN, RST_PROP_GAIN);
    write_reg(REG_INT_COEF, RST_INT_COEF);
    push_sample('0, '0);
    push_sample(WORD_MAX, '0);
    push_sample(WORD_MIN, '0);
    push_sample(word_t'(32'sd327680), word_t'(32'sd131072));
    drain();

    pressure_go = 1'b1;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph % 3 == 2) begin
        // Arbitrary register contents, crossed limits included
        write_reg(REG_PROP_GAIN, pick_word());
        write_reg(REG_INT_COEF, pick_word());
        write_reg(REG_DERIV_COEF, pick_word());
        write_reg(REG_DERIV_DECAY, pick_word());
        write_reg(REG_OUT_MAX, pick_word());
        write_reg(REG_OUT_MIN, pick_word());
        write_reg(REG_INTEG_MAX, pick_word());
        write_reg(REG_INTEG_MIN, pick_word());
      end else begin
        // Plausible tuning so the loop spends time between its limits
        write_reg(REG_PROP_GAIN, word_t'($urandom_range(0, 8 << FRAC_BITS))
                  * (($urandom_range(0, 5) == 0) ? -1 : 1));
        write_reg(REG_INT_COEF, word_t'($urandom_range(0, 8192)));
        write_reg(REG_DERIV_COEF, word_t'($urandom_range(0, 1 << FRAC_BITS)));
        write_reg(REG_DERIV_DECAY, word_t'($urandom_range(0, (1 << FRAC_BITS) - 1)));
        lim_hi = pick_limit();
        lim_lo = ($urandom_range(0, 1) == 0) ? -lim_hi : -pick_limit();
        write_reg(REG_OUT_MAX, lim_hi);
        write_reg(REG_OUT_MIN, lim_lo);
        lim_hi = pick_limit() >>> 1;
        write_reg(REG_INTEG_MAX, lim_hi);
        write_reg(REG_INTEG_MIN, -lim_hi);
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_INDEX, LAST_UNUSED_INDEX)),
                  pick_word());

      setpoint = 0;
      plant = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 3) != 0) begin
          // Track a setpoint with a crude first-order plant plus noise
          if ($urandom_range(0, 19) == 0)
            setpoint = int'($urandom_range(0, 200 << FRAC_BITS)) - (100 << FRAC_BITS);
          plant = plant + (setpoint - plant) / 8
                  + int'($urandom_range(0, 1 << FRAC_BITS)) - (1 << (FRAC_BITS - 1));
          push_sample(word_t'(setpoint), word_t'(plant));
        end else begin
          push_sample(pick_word(), pick_word());
        end
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
